// ===== hdl/lpht_pkg.sv =====
// Shared widths, operation and status codes, and hash constants for the
// linear probe hash table. No dependencies.
package lpht_pkg;

   localparam int KEY_W      = 64;
   localparam int CHAR_W     = 8;
   localparam int MAX_CHARS  = 8;
   localparam int CHAR_IDX_W = 3;
   localparam int VALUE_W    = 16;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int ENTRIES_W  = 7;

   localparam logic [KEY_W-1:0] HASH_SEED  = 64'd5381;
   localparam int               HASH_SHIFT = 5;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Write enables of the slot memory.
   typedef struct packed {
      logic key_en;
      logic value_en;
   } mem_wr_type;

endpackage

// ===== hdl/lpht_if.sv =====
// Request and response channel interfaces of the hash table.
// Depends on lpht_pkg for the payload widths.
interface lpht_req_if import lpht_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [KEY_W-1:0]          key_bytes;
   logic signed [VALUE_W-1:0] new_value;

   modport source (output valid, output func, output key_bytes, output new_value,
                   input ready);
   modport sink (input valid, input func, input key_bytes, input new_value,
                 output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] result_value;
   logic [STATUS_W-1:0]       status;
   logic [ENTRIES_W-1:0]      entries_used;

   modport source (output valid, output result_value, output status,
                   output entries_used, input ready);
   modport sink (input valid, input result_value, input status,
                 input entries_used, output ready);
endinterface

// ===== hdl/lpht_hash.sv =====
// Iterative djb2-xor hash unit, one key character per cycle.
// Depends on lpht_pkg.
module lpht_hash import lpht_pkg::*; #(
   parameter int ADDR_W    = 6,
   parameter int KEY_CHARS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KEY_W-1:0]  key,
   output logic              done,
   output logic [ADDR_W-1:0] home
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CHAR_IDX_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0]     h_ff, h_in;
   logic [KEY_W-1:0]      key_ff, key_in;

   logic [CHAR_W-1:0]     char_c;
   logic [ADDR_W-1:0]     char_ext;
   logic [ADDR_W-1:0]     h_step;
   logic                  last_char;

   // Only the low address bits of the hash are ever used, and those depend
   // only on the low bits of the running value, so the state is kept narrow.
   assign char_c    = key_ff[idx_ff*CHAR_W +: CHAR_W];
   assign char_ext  = ADDR_W'({{(KEY_W-CHAR_W){char_c[CHAR_W-1]}}, char_c});
   assign h_step    = (ADDR_W'(h_ff << HASH_SHIFT) + h_ff) ^ char_ext;
   assign last_char = (idx_ff == CHAR_IDX_W'(KEY_CHARS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      h_in    = h_ff;
      key_in  = key_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         h_in    = ADDR_W'(HASH_SEED);
         key_in  = key;
      end else if (busy_ff) begin
         if (char_c == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            h_in = h_step;
            if (last_char) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      h_ff   <= h_in;
      key_ff <= key_in;
   end

   assign done = done_ff;
   assign home = h_ff;

endmodule

// ===== hdl/lpht_slot_mem.sv =====
// Slot storage: key memory and value memory, one write and one registered
// read port each, sharing addresses. Depends on lpht_pkg.
module lpht_slot_mem import lpht_pkg::*; #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                      clock,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [KEY_W-1:0]          rd_key,
   output logic signed [VALUE_W-1:0] rd_value,
   input  mem_wr_type                wr,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [KEY_W-1:0]          wr_key,
   input  logic signed [VALUE_W-1:0] wr_value
);

   logic [KEY_W-1:0]          key_mem [DEPTH];
   logic signed [VALUE_W-1:0] value_mem [DEPTH];
   logic [KEY_W-1:0]          rd_key_ff;
   logic signed [VALUE_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.value_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
// Top level of the open-addressing hash table of short string keys.
// Depends on lpht_pkg, lpht_if, lpht_hash and lpht_slot_mem.
//
// Usage: each request beat on req_chan carries an operation (insert or
// update, lookup, remove), a key of up to KEY_CHARS bytes ending at the first
// zero byte, and a value for inserts. Every request yields exactly one
// response beat on rsp_chan with the found or removed value, a status code
// and the number of occupied slots after the operation.
// The block works on one request at a time. The key is hashed one character
// per cycle, then the table is probed linearly one slot per cycle through the
// single read port of the slot memory. The response register is loaded when
// the request reaches its final state and the register is free; only then
// does the block return to idle and take the next request.
// Requests with an empty key or the unused operation code skip the hash and
// the probe and go straight to the final state.
// After reset the key memory is cleared one slot per cycle; req_chan.ready
// stays low during that pass.
// The response sits in an output register. A new request is taken while an
// earlier response still waits; a finished request whose response cannot be
// placed holds in its final state, and its table write is made only when the
// response register is loaded, so a stalled receiver never loses a beat.
// TABLE_DEPTH must be a power of two.
module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_CHARS   = 8
) (
   input  logic       clock,
   input  logic       reset,
   lpht_req_if.sink   req_chan,
   lpht_rsp_if.source rsp_chan
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // Keep the key bytes up to the first zero byte and at most KEY_CHARS of
   // them; this is the form in which keys are stored and compared.
   function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] k;
      logic             live;
      k    = '0;
      live = 1'b1;
      for (int i = 0; i < MAX_CHARS; i++) begin
         if (i >= KEY_CHARS || raw[i*CHAR_W +: CHAR_W] == '0) begin
            live = 1'b0;
         end
         if (live) begin
            k[i*CHAR_W +: CHAR_W] = raw[i*CHAR_W +: CHAR_W];
         end
      end
      return k;
   endfunction

   logic [2:0]                state_ff, state_in;
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   logic [FUNC_W-1:0]         func_ff, func_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic [ADDR_W-1:0]         step_ff, step_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [VALUE_W-1:0] pend_value_ff, pend_value_in;
   logic [STATUS_W-1:0]       pend_status_ff, pend_status_in;
   mem_wr_type                pend_wr_ff, pend_wr_in;
   logic                      pend_inc_ff, pend_inc_in;
   logic                      pend_dec_ff, pend_dec_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [ENTRIES_W-1:0]      rsp_entries_ff, rsp_entries_in;

   logic [KEY_W-1:0]          key_norm;
   logic                      req_accept;
   logic                      out_free;
   logic                      hash_start;
   logic                      hash_done;
   logic [ADDR_W-1:0]         hash_home;
   logic [ADDR_W-1:0]         rd_addr;
   logic [KEY_W-1:0]          rd_key;
   logic signed [VALUE_W-1:0] rd_value;
   mem_wr_type                mem_wr;
   logic [ADDR_W-1:0]         wr_addr;
   logic [KEY_W-1:0]          wr_key;
   logic                      key_match;
   logic                      slot_empty;
   logic                      last_step;
   logic [CNT_W-1:0]          count_upd;

   assign key_norm   = norm_key(req_chan.key_bytes);
   assign req_accept = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign hash_start = req_accept && (req_chan.func != FUNC_NONE)
                       && (key_norm[CHAR_W-1:0] != '0);

   // Probe comparisons against the slot read in the previous cycle. The key
   // under search is never empty, so a match and an empty slot exclude
   // each other.
   assign key_match  = (rd_key == key_ff);
   assign slot_empty = (rd_key[CHAR_W-1:0] == '0);
   assign last_step  = (step_ff == {ADDR_W{1'b1}});

   // The count moves by at most one; the decrement guard keeps it from
   // wrapping below zero.
   always_comb begin
      count_upd = count_ff;
      if (pend_inc_ff) begin
         count_upd = count_ff + 1'b1;
      end else if (pend_dec_ff && count_ff != '0) begin
         count_upd = count_ff - 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      idx_in         = idx_ff;
      step_in        = step_ff;
      count_in       = count_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      pend_wr_in     = pend_wr_ff;
      pend_inc_in    = pend_inc_ff;
      pend_dec_in    = pend_dec_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_entries_in = rsp_entries_ff;
      rd_addr        = idx_ff;
      mem_wr         = '0;
      wr_addr        = idx_ff;
      wr_key         = key_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr.key_en = 1'b1;
            wr_addr       = clr_addr_ff;
            wr_key        = '0;
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {ADDR_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               func_in       = req_chan.func;
               key_in        = key_norm;
               val_in        = req_chan.new_value;
               pend_value_in = '0;
               pend_wr_in    = '0;
               pend_inc_in   = 1'b0;
               pend_dec_in   = 1'b0;
               if (req_chan.func == FUNC_NONE) begin
                  pend_status_in = STATUS_OK;
                  state_in       = ST_DONE;
               end else if (key_norm[CHAR_W-1:0] == '0) begin
                  pend_status_in = STATUS_NOT_FOUND;
                  state_in       = ST_DONE;
               end else begin
                  pend_status_in = STATUS_OK;
                  state_in       = ST_HASH;
               end
            end
         end

         ST_HASH: begin
            // Issue the read of the home slot as soon as the hash is ready.
            if (hash_done) begin
               rd_addr  = hash_home;
               idx_in   = hash_home;
               step_in  = '0;
               state_in = ST_PROBE;
            end
         end

         ST_PROBE: begin
            if (key_match) begin
               state_in = ST_DONE;
               case (func_ff)
                  FUNC_INSERT: begin
                     pend_wr_in.value_en = 1'b1;
                  end
                  FUNC_REMOVE: begin
                     pend_value_in     = rd_value;
                     pend_wr_in.key_en = 1'b1;
                     pend_dec_in       = 1'b1;
                  end
                  default: begin
                     pend_value_in = rd_value;
                  end
               endcase
            end else if (slot_empty) begin
               state_in = ST_DONE;
               if (func_ff == FUNC_INSERT) begin
                  pend_wr_in.key_en   = 1'b1;
                  pend_wr_in.value_en = 1'b1;
                  pend_inc_in         = 1'b1;
               end else begin
                  pend_status_in = STATUS_NOT_FOUND;
               end
            end else if (last_step) begin
               // Every slot visited without a match or a free slot.
               state_in = ST_DONE;
               if (func_ff == FUNC_INSERT) begin
                  pend_status_in = STATUS_FULL;
               end else begin
                  pend_status_in = STATUS_NOT_FOUND;
               end
            end else begin
               // Wrap-around comes for free with a power-of-two depth.
               idx_in  = idx_ff + 1'b1;
               step_in = step_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end

         ST_DONE: begin
            // The table write and the count update happen together with the
            // load of the response register.
            if (out_free) begin
               mem_wr         = pend_wr_ff;
               wr_key         = pend_dec_ff ? '0 : key_ff;
               count_in       = count_upd;
               rsp_valid_in   = 1'b1;
               rsp_value_in   = pend_value_ff;
               rsp_status_in  = pend_status_ff;
               rsp_entries_in = ENTRIES_W'(count_upd);
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff        <= func_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      idx_ff         <= idx_in;
      step_ff        <= step_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      pend_wr_ff     <= pend_wr_in;
      pend_inc_ff    <= pend_inc_in;
      pend_dec_ff    <= pend_dec_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   lpht_hash #(
      .ADDR_W    (ADDR_W),
      .KEY_CHARS (KEY_CHARS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_norm),
      .done  (hash_done),
      .home  (hash_home)
   );

   lpht_slot_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_slot_mem (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .wr       (mem_wr),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_value (val_ff)
   );

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.entries_used = rsp_entries_ff;

   // The occupancy count can never exceed the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("occupancy count above table depth");

   // A table-full status is only ever produced by an insert.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free && pend_status_ff == STATUS_FULL)
      |-> (func_ff == FUNC_INSERT))
      else $error("table-full status for an operation other than insert");

   // The table is never written while a search is still reading it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HASH || state_ff == ST_PROBE)
      |-> (!mem_wr.key_en && !mem_wr.value_en))
      else $error("slot memory written during hash or probe");

   // A response is loaded only on the way back to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |=> (state_ff == ST_IDLE))
      else $error("response loaded outside the final step of a request");

endmodule
